// File: rtl/srclex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source text lexer package
// Shared widths, token kinds, scan modes, token records and keyword tables.
// ----------------------------------------------------------------------------
package srclex_pkg;

    localparam int OffsetBits   = 20;
    localparam int LineBits     = 20;
    localparam int KeywordChars = 10;
    localparam int WlenBits     = $clog2(KeywordChars + 2);
    localparam int QDepth       = 8;
    localparam int QPtrBits     = $clog2(QDepth);

    localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};
    localparam logic [LineBits-1:0]   LineMax   = {LineBits{1'b1}};

    localparam logic [5:0] TK_LPAREN  = 6'd0;
    localparam logic [5:0] TK_RPAREN  = 6'd1;
    localparam logic [5:0] TK_LBRACE  = 6'd2;
    localparam logic [5:0] TK_RBRACE  = 6'd3;
    localparam logic [5:0] TK_LBRACK  = 6'd4;
    localparam logic [5:0] TK_RBRACK  = 6'd5;
    localparam logic [5:0] TK_COMMA   = 6'd6;
    localparam logic [5:0] TK_DOT     = 6'd7;
    localparam logic [5:0] TK_MINUS   = 6'd8;
    localparam logic [5:0] TK_PLUS    = 6'd9;
    localparam logic [5:0] TK_SEMI    = 6'd10;
    localparam logic [5:0] TK_SLASH   = 6'd11;
    localparam logic [5:0] TK_STAR    = 6'd12;
    localparam logic [5:0] TK_BANG    = 6'd13;
    localparam logic [5:0] TK_EQUAL   = 6'd15;
    localparam logic [5:0] TK_GREATER = 6'd17;
    localparam logic [5:0] TK_LESS    = 6'd19;
    localparam logic [5:0] TK_IDENT   = 6'd21;
    localparam logic [5:0] TK_STRING  = 6'd22;
    localparam logic [5:0] TK_NUMBER  = 6'd23;
    localparam logic [5:0] TK_UNTERM  = 6'd40;
    localparam logic [5:0] TK_UNEXP   = 6'd41;
    localparam logic [5:0] TK_EOF     = 6'd42;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_COMMENT = 8'b0000_0010,
        M_INT     = 8'b0000_0100,
        M_DOT     = 8'b0000_1000,
        M_FRAC    = 8'b0001_0000,
        M_STRING  = 8'b0010_0000,
        M_WORD    = 8'b0100_0000,
        M_OP      = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [5:0]            kind;
        logic [OffsetBits-1:0] start;
        logic [OffsetBits-1:0] len;
        logic [LineBits-1:0]   line;
        logic                  last;
    } t_tok;

    typedef struct packed {
        logic [1:0]     num;
        t_tok [2:0]     tok;
    } t_emit;

    typedef struct packed {
        logic [QPtrBits:0] count;
    } t_qstat;

    typedef logic [KeywordChars-1:0][7:0] t_wbuf;

    typedef struct packed {
        logic [8*KeywordChars-1:0] text;
        logic [WlenBits-1:0]       len;
        logic [5:0]                kind;
    } t_kw;

    // Text is right-aligned: the first character sits in the highest used byte.
    localparam t_kw KwStd [16] = '{
        '{80'("and"), 4'd3, 6'd24},   '{80'("class"), 4'd5, 6'd25},
        '{80'("else"), 4'd4, 6'd26},  '{80'("false"), 4'd5, 6'd27},
        '{80'("for"), 4'd3, 6'd28},   '{80'("fun"), 4'd3, 6'd29},
        '{80'("if"), 4'd2, 6'd30},    '{80'("null"), 4'd4, 6'd31},
        '{80'("or"), 4'd2, 6'd32},    '{80'("print"), 4'd5, 6'd33},
        '{80'("return"), 4'd6, 6'd34},'{80'("super"), 4'd5, 6'd35},
        '{80'("this"), 4'd4, 6'd36},  '{80'("true"), 4'd4, 6'd37},
        '{80'("var"), 4'd3, 6'd38},   '{80'("while"), 4'd5, 6'd39}
    };

    localparam t_kw KwAlt [13] = '{
        '{80'("agentic"), 4'd7, 6'd28},   '{80'("b2b"), 4'd3, 6'd39},
        '{80'("blockchain"), 4'd10, 6'd31},'{80'("bootstrap"), 4'd9, 6'd38},
        '{80'("burnout"), 4'd7, 6'd27},   '{80'("disrupt"), 4'd7, 6'd30},
        '{80'("leverage"), 4'd8, 6'd33},  '{80'("mvp"), 4'd3, 6'd29},
        '{80'("pivot"), 4'd5, 6'd26},     '{80'("saas"), 4'd4, 6'd34},
        '{80'("scale"), 4'd5, 6'd32},     '{80'("synergy"), 4'd7, 6'd24},
        '{80'("unicorn"), 4'd7, 6'd37}
    };

    function automatic logic kw_match(t_kw e, t_wbuf buf_w, logic [WlenBits-1:0] wlen);
        logic ok;
        int   k;
        ok = (e.len == wlen);
        for (int i = 0; i < KeywordChars; i++) begin
            k = int'(e.len) - 1 - i;
            if (k >= 0 && buf_w[i] != e.text[k*8 +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [5:0] word_kind(t_wbuf buf_w, logic [WlenBits-1:0] wlen,
                                             logic kw_set);
        logic [5:0] kind;
        kind = TK_IDENT;
        if (!kw_set) begin
            for (int i = 0; i < 16; i++) begin
                if (kw_match(KwStd[i], buf_w, wlen)) kind = KwStd[i].kind;
            end
        end else begin
            for (int i = 0; i < 13; i++) begin
                if (kw_match(KwAlt[i], buf_w, wlen)) kind = KwAlt[i].kind;
            end
        end
        return kind;
    endfunction

    function automatic logic [OffsetBits-1:0] sdiff(logic [OffsetBits-1:0] a,
                                                   logic [OffsetBits-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage
`default_nettype wire

// File: rtl/srclex_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source text lexer scanner
// Consumes one byte per cycle while i_take is high, tracks the scan mode and
// counters, and produces up to three token records for each byte.
// ----------------------------------------------------------------------------
module srclex_scan
    import srclex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_char,
    input  wire logic       i_kw_set,
    output t_emit           o_emit
);

    t_mode                 r_mode, n_mode;
    logic [OffsetBits-1:0] r_off, n_off, r_start, n_start;
    logic [LineBits-1:0]   r_line, n_line;
    logic [7:0]            r_pend, n_pend;
    logic [WlenBits-1:0]   r_wlen, n_wlen;
    t_wbuf                 r_wbuf;
    logic                  wr_en;
    logic [WlenBits-1:0]   wr_idx;

    t_tok [2:0]            tk;
    logic [1:0]            k;
    logic                  do_idle, ended, is_dig, is_alp;
    logic [OffsetBits-1:0] pos;
    logic [5:0]            op_k;

    function automatic t_tok mk(logic [5:0] kd, logic [OffsetBits-1:0] st,
                                logic [OffsetBits-1:0] ln, logic [LineBits-1:0] lc);
        t_tok t;
        t.kind  = kd;
        t.start = st;
        t.len   = ln;
        t.line  = lc;
        t.last  = 1'b0;
        return t;
    endfunction

    always_comb begin
        pos    = r_off;
        is_dig = (i_char >= "0") && (i_char <= "9");
        is_alp = ((i_char >= "a") && (i_char <= "z")) || ((i_char >= "A") && (i_char <= "Z"))
                 || (i_char == "_");
        case (r_pend)
            "!":     op_k = TK_BANG;
            "=":     op_k = TK_EQUAL;
            ">":     op_k = TK_GREATER;
            default: op_k = TK_LESS;
        endcase
        n_mode  = r_mode;
        n_start = r_start;
        n_line  = r_line;
        n_pend  = r_pend;
        n_wlen  = r_wlen;
        n_off   = r_off;
        wr_en   = 1'b0;
        wr_idx  = r_wlen;
        tk      = '0;
        k       = 2'd0;
        do_idle = 1'b0;
        ended   = 1'b0;

        case (r_mode)
            M_COMMENT: begin
                if (i_char == 8'h0A || i_char == 8'h00) do_idle = 1'b1;
            end
            M_INT, M_FRAC: begin
                if (i_char == "." && r_mode == M_INT) begin
                    n_mode = M_DOT;
                end else if (!is_dig) begin
                    tk[k] = mk(TK_NUMBER, r_start, sdiff(pos, r_start), r_line);
                    k = k + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_DOT: begin
                if (is_dig) begin
                    n_mode = M_FRAC;
                end else begin
                    tk[k] = mk(TK_NUMBER, r_start, sdiff(sdiff(pos, OffsetBits'(1)), r_start),
                               r_line);
                    k = k + 2'd1;
                    tk[k] = mk(TK_DOT, sdiff(pos, OffsetBits'(1)), OffsetBits'(1), r_line);
                    k = k + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_WORD: begin
                if (is_alp || is_dig) begin
                    if (r_wlen <= WlenBits'(KeywordChars)) begin
                        wr_en  = (r_wlen < WlenBits'(KeywordChars));
                        n_wlen = r_wlen + 1'b1;
                    end
                end else begin
                    tk[k] = mk((r_wlen > WlenBits'(KeywordChars)) ? TK_IDENT
                               : word_kind(r_wbuf, r_wlen, i_kw_set),
                               r_start, sdiff(pos, r_start), r_line);
                    k = k + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_OP: begin
                if (i_char == "=") begin
                    tk[k] = mk(op_k + 6'd1, r_start, sdiff(pos, r_start) + 1'b1, r_line);
                    k = k + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    tk[k] = mk(op_k, r_start, OffsetBits'(1), r_line);
                    k = k + 2'd1;
                    do_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (i_char == 8'h22) begin
                    tk[k] = mk(TK_STRING, r_start, sdiff(pos, r_start) + 1'b1, r_line);
                    k = k + 2'd1;
                    n_mode = M_IDLE;
                end else if (i_char == 8'h00) begin
                    tk[k] = mk(TK_UNTERM, r_start, sdiff(pos, r_start), r_line);
                    k = k + 2'd1;
                    do_idle = 1'b1;
                end else if (i_char == 8'h0A) begin
                    if (r_line < LineMax) n_line = r_line + 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
            n_mode = M_IDLE;
            if (i_char == 8'h00) begin
                tk[k] = mk(TK_EOF, pos, '0, r_line);
                k = k + 2'd1;
                n_off   = '0;
                n_line  = LineBits'(1);
                n_start = '0;
                ended   = 1'b1;
            end else begin
                n_start = pos;
                if (is_dig) begin
                    n_mode = M_INT;
                end else if (is_alp) begin
                    n_mode = M_WORD;
                    wr_en  = 1'b1;
                    wr_idx = '0;
                    n_wlen = WlenBits'(1);
                end else begin
                    case (i_char)
                        8'h20, 8'h0D, 8'h09: ;
                        8'h0A: if (r_line < LineMax) n_line = r_line + 1'b1;
                        "#": n_mode = M_COMMENT;
                        "(": begin tk[k] = mk(TK_LPAREN, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        ")": begin tk[k] = mk(TK_RPAREN, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "{": begin tk[k] = mk(TK_LBRACE, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "}": begin tk[k] = mk(TK_RBRACE, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "[": begin tk[k] = mk(TK_LBRACK, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "]": begin tk[k] = mk(TK_RBRACK, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        ",": begin tk[k] = mk(TK_COMMA, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        ".": begin tk[k] = mk(TK_DOT, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "-": begin tk[k] = mk(TK_MINUS, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "+": begin tk[k] = mk(TK_PLUS, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        ";": begin tk[k] = mk(TK_SEMI, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "/": begin tk[k] = mk(TK_SLASH, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "*": begin tk[k] = mk(TK_STAR, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                        "!", "=", "<", ">": begin
                            n_mode = M_OP;
                            n_pend = i_char;
                        end
                        8'h22: n_mode = M_STRING;
                        default: begin tk[k] = mk(TK_UNEXP, pos, OffsetBits'(1), r_line);
                            k = k + 2'd1; end
                    endcase
                end
            end
        end

        if (!ended && r_off < OffsetMax) n_off = r_off + 1'b1;
        if (k != 2'd0) tk[k - 2'd1].last = 1'b1;
        o_emit.tok = tk;
        o_emit.num = i_take ? k : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_off   <= '0;
            r_start <= '0;
            r_line  <= LineBits'(1);
            r_pend  <= '0;
            r_wlen  <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_off   <= n_off;
            r_start <= n_start;
            r_line  <= n_line;
            r_pend  <= n_pend;
            r_wlen  <= n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && wr_en) begin
            r_wbuf[wr_idx[$clog2(KeywordChars)-1:0]] <= i_char;
        end
    end

endmodule
`default_nettype wire

// File: rtl/srclex_tokq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source text lexer token queue
// Takes up to three token words per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module srclex_tokq
    import srclex_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_emit     i_emit,
    input  wire logic i_pop,
    output t_tok      o_head,
    output t_qstat    o_stat
);

    t_tok [QDepth-1:0]   r_q;
    logic [QPtrBits-1:0] r_wp, r_rp;
    logic [QPtrBits:0]   r_cnt;
    logic                take;

    assign take        = i_pop && (r_cnt != '0);
    assign o_head      = r_q[r_rp];
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QPtrBits'(i_emit.num);
            r_rp  <= r_rp + QPtrBits'(take);
            r_cnt <= r_cnt + (QPtrBits+1)'(i_emit.num) - (QPtrBits+1)'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i < int'(i_emit.num)) begin
                r_q[r_wp + QPtrBits'(i)] <= i_emit.tok[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/source_text_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Source text lexer
// Byte-stream lexical scanner with a token queue on its output side.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per clock cycle and writes the tokens that
// byte completes (up to three) into an eight-word token queue in the same
// cycle; tokens leave the queue one per cycle while popped. A byte is refused
// only while fewer than three queue words are free, so input runs at one byte
// per cycle as long as the consumer keeps up with the token rate. Byte 0 ends
// a source and yields any pending token and then an end-of-file word.
module source_text_lexer
    import srclex_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_wdata,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            i_char_byte,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [5:0]                 o_token_kind,
    output logic [OffsetBits-1:0]      o_start_offset,
    output logic [OffsetBits-1:0]      o_token_length,
    output logic [LineBits-1:0]        o_line_number,
    output logic                       o_last_of_run
);

    logic   r_kw_set;
    logic   take;
    t_emit  emit_w;
    t_tok   head;
    t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_set <= 1'b0;
        end else if (i_cfg_we) begin
            r_kw_set <= i_cfg_wdata;
        end
    end

    assign full  = (qstat.count > (QPtrBits+1)'(QDepth - 3));
    assign empty = (qstat.count == '0);
    assign take  = push && !full;

    srclex_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_char   (i_char_byte),
        .i_kw_set (r_kw_set),
        .o_emit   (emit_w)
    );

    srclex_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit_w),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    assign o_token_kind   = head.kind;
    assign o_start_offset = head.start;
    assign o_token_length = head.len;
    assign o_line_number  = head.line;
    assign o_last_of_run  = head.last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= (QPtrBits+1)'(QDepth))
        else $error("token queue count exceeds depth");
    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |-> emit_w.num == 2'd0)
        else $error("tokens written without an accepted byte");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == TK_EOF) |-> o_last_of_run)
        else $error("end-of-file word not marked last");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !take) |=> qstat.count == $past(qstat.count) - 1'b1)
        else $error("queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

// File: test/source_text_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text lexer testbench
// Streams directed and random source text into the lexer, predicts every
// token in a behavioral scanner of its own and checks each token word in
// order, with random idle cycles on both sides and both keyword sets.
// ----------------------------------------------------------------------------
module source_text_lexer_tb;
    import srclex_pkg::*;

    logic                  i_clk = 1'b1;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_char_byte = 8'd0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [5:0]            o_token_kind;
    logic [OffsetBits-1:0] o_start_offset;
    logic [OffsetBits-1:0] o_token_length;
    logic [LineBits-1:0]   o_line_number;
    logic                  o_last_of_run;

    source_text_lexer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full), .i_char_byte(i_char_byte),
        .empty(empty), .pop(pop),
        .o_token_kind(o_token_kind), .o_start_offset(o_start_offset),
        .o_token_length(o_token_length), .o_line_number(o_line_number),
        .o_last_of_run(o_last_of_run)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    logic [7:0] source_bytes[$];
    t_tok       expected_tokens[$];
    t_tok       run_toks[$];
    bit         failed = 1'b0;

    // Scanner state mirrored from the block's behavior.
    logic                  kw_set = 1'b0;
    logic [OffsetBits-1:0] scan_pos = '0;
    logic [OffsetBits-1:0] tok_begin = '0;
    logic [LineBits-1:0]   line_cnt = LineBits'(1);
    t_mode                 scan_mode = M_IDLE;
    logic [7:0]            op_char = 8'd0;
    string                 word_text = "";
    int                    word_len = 0;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [OffsetBits-1:0] sat_sub(logic [OffsetBits-1:0] a,
                                                     logic [OffsetBits-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic void add_tok(logic [5:0] kind, logic [OffsetBits-1:0] start,
                                    logic [OffsetBits-1:0] len);
        t_tok t;
        if (run_toks.size() < 3) begin
            t.kind  = kind;
            t.start = start;
            t.len   = len;
            t.line  = line_cnt;
            t.last  = 1'b0;
            run_toks.push_back(t);
        end
    endfunction

    function automatic void bump_line();
        if (line_cnt != LineMax) line_cnt = line_cnt + 1'b1;
    endfunction

    function automatic void add_word_char(logic [7:0] c);
        if (word_len <= KeywordChars) begin
            if (word_len < KeywordChars) word_text = {word_text, string'(c)};
            word_len++;
        end
    endfunction

    function automatic logic [5:0] word_token();
        if (word_len > KeywordChars) return TK_IDENT;
        if (!kw_set) begin
            case (word_text)
                "and":    return 6'd24;
                "class":  return 6'd25;
                "else":   return 6'd26;
                "false":  return 6'd27;
                "for":    return 6'd28;
                "fun":    return 6'd29;
                "if":     return 6'd30;
                "null":   return 6'd31;
                "or":     return 6'd32;
                "print":  return 6'd33;
                "return": return 6'd34;
                "super":  return 6'd35;
                "this":   return 6'd36;
                "true":   return 6'd37;
                "var":    return 6'd38;
                "while":  return 6'd39;
                default:  return TK_IDENT;
            endcase
        end
        case (word_text)
            "agentic":    return 6'd28;
            "b2b":        return 6'd39;
            "blockchain": return 6'd31;
            "bootstrap":  return 6'd38;
            "burnout":    return 6'd27;
            "disrupt":    return 6'd30;
            "leverage":   return 6'd33;
            "mvp":        return 6'd29;
            "pivot":      return 6'd26;
            "saas":       return 6'd34;
            "scale":      return 6'd32;
            "synergy":    return 6'd24;
            "unicorn":    return 6'd37;
            default:      return TK_IDENT;
        endcase
    endfunction

    function automatic logic [5:0] op_token();
        case (op_char)
            "!":     return TK_BANG;
            "=":     return TK_EQUAL;
            ">":     return TK_GREATER;
            default: return TK_LESS;
        endcase
    endfunction

    // Byte seen between tokens; returns 1 when it ends the source.
    function automatic bit start_token(logic [7:0] c, logic [OffsetBits-1:0] pos);
        scan_mode = M_IDLE;
        if (c == 8'd0) begin
            add_tok(TK_EOF, pos, '0);
            scan_pos  = '0;
            line_cnt  = LineBits'(1);
            tok_begin = '0;
            return 1'b1;
        end
        tok_begin = pos;
        if (is_digit(c)) begin
            scan_mode = M_INT;
        end else if (is_alpha(c)) begin
            scan_mode = M_WORD;
            word_len  = 0;
            word_text = "";
            add_word_char(c);
        end else begin
            case (c)
                " ", 8'h0D, 8'h09: ;
                8'h0A: bump_line();
                "#": scan_mode = M_COMMENT;
                "(": add_tok(TK_LPAREN, pos, 1);
                ")": add_tok(TK_RPAREN, pos, 1);
                "{": add_tok(TK_LBRACE, pos, 1);
                "}": add_tok(TK_RBRACE, pos, 1);
                "[": add_tok(TK_LBRACK, pos, 1);
                "]": add_tok(TK_RBRACK, pos, 1);
                ",": add_tok(TK_COMMA, pos, 1);
                ".": add_tok(TK_DOT, pos, 1);
                "-": add_tok(TK_MINUS, pos, 1);
                "+": add_tok(TK_PLUS, pos, 1);
                ";": add_tok(TK_SEMI, pos, 1);
                "/": add_tok(TK_SLASH, pos, 1);
                "*": add_tok(TK_STAR, pos, 1);
                "!", "=", "<", ">": begin
                    scan_mode = M_OP;
                    op_char   = c;
                end
                "\"": scan_mode = M_STRING;
                default: add_tok(TK_UNEXP, pos, 1);
            endcase
        end
        return 1'b0;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [OffsetBits-1:0] pos;
        bit ended;
        pos   = scan_pos;
        ended = 1'b0;
        run_toks.delete();
        case (scan_mode)
            M_COMMENT: if (c == 8'h0A || c == 8'd0) ended = start_token(c, pos);
            M_INT: begin
                if (c == ".") scan_mode = M_DOT;
                else if (!is_digit(c)) begin
                    add_tok(TK_NUMBER, tok_begin, sat_sub(pos, tok_begin));
                    ended = start_token(c, pos);
                end
            end
            M_DOT: begin
                if (is_digit(c)) scan_mode = M_FRAC;
                else begin
                    // The dot was not a fraction: number and dot come out together.
                    add_tok(TK_NUMBER, tok_begin, sat_sub(sat_sub(pos, 1), tok_begin));
                    add_tok(TK_DOT, sat_sub(pos, 1), 1);
                    ended = start_token(c, pos);
                end
            end
            M_FRAC: begin
                if (!is_digit(c)) begin
                    add_tok(TK_NUMBER, tok_begin, sat_sub(pos, tok_begin));
                    ended = start_token(c, pos);
                end
            end
            M_WORD: begin
                if (is_alpha(c) || is_digit(c)) add_word_char(c);
                else begin
                    add_tok(word_token(), tok_begin, sat_sub(pos, tok_begin));
                    ended = start_token(c, pos);
                end
            end
            M_OP: begin
                if (c == "=") begin
                    add_tok(op_token() + 6'd1, tok_begin, sat_sub(pos, tok_begin) + 1'b1);
                    scan_mode = M_IDLE;
                end else begin
                    add_tok(op_token(), tok_begin, 1);
                    ended = start_token(c, pos);
                end
            end
            M_STRING: begin
                if (c == "\"") begin
                    add_tok(TK_STRING, tok_begin, sat_sub(pos, tok_begin) + 1'b1);
                    scan_mode = M_IDLE;
                end else if (c == 8'd0) begin
                    add_tok(TK_UNTERM, tok_begin, sat_sub(pos, tok_begin));
                    ended = start_token(c, pos);
                end else if (c == 8'h0A) begin
                    bump_line();
                end
            end
            default: ended = start_token(c, pos);
        endcase
        if (!ended && scan_pos != OffsetMax) scan_pos = scan_pos + 1'b1;
        if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1'b1;
        foreach (run_toks[i]) expected_tokens.push_back(run_toks[i]);
    endfunction

    // Sender: one byte per word, random gaps, occasional runs without gaps.
    int  send_gap = 0;
    bit  send_burst = 1'b0;

    always @(posedge i_clk) begin : sender
        bit accepted;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            accepted = push && !full;
            if (accepted) begin
                lex_byte(i_char_byte);
                if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 4);
            end
            if (push && !accepted) begin
                push <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (source_bytes.size() > 0) begin
                push        <= 1'b1;
                i_char_byte <= source_bytes.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: checks each token word against the oldest prediction.
    int  recv_gap = 0;
    bit  recv_burst = 1'b0;

    always @(posedge i_clk) begin : receiver
        t_tok want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_tokens.size() == 0) begin
                    $error("token word with none expected: kind %0d", o_token_kind);
                    failed = 1'b1;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                        failed = 1'b1;
                    end
                    if (o_start_offset !== want.start) begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start, o_start_offset);
                        failed = 1'b1;
                    end
                    if (o_token_length !== want.len) begin
                        $error("token_length: expected %0d, got %0d",
                               want.len, o_token_length);
                        failed = 1'b1;
                    end
                    if (o_line_number !== want.line) begin
                        $error("line_number: expected %0d, got %0d",
                               want.line, o_line_number);
                        failed = 1'b1;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last, o_last_of_run);
                        failed = 1'b1;
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 4);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    string std_words[16] = '{"and", "class", "else", "false", "for", "fun", "if", "null",
                             "or", "print", "return", "super", "this", "true", "var",
                             "while"};
    string alt_words[13] = '{"agentic", "b2b", "blockchain", "bootstrap", "burnout",
                             "disrupt", "leverage", "mvp", "pivot", "saas", "scale",
                             "synergy", "unicorn"};
    string ops[10] = '{"(", ")", "{", "}", "[", "]", ",", "-", "+", ";"};
    string op_starts = "!=<>";
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
    endtask

    task automatic add_digits();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) source_bytes.push_back(8'(48 + $urandom_range(0, 9)));
    endtask

    task automatic add_fragment();
        int n;
        case ($urandom_range(0, 14))
            0, 1: add_text(std_words[$urandom_range(0, 15)]);
            2, 3: add_text(alt_words[$urandom_range(0, 12)]);
            4: begin
                // Identifier, sometimes longer than the keyword buffer.
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
                source_bytes.push_back(word_chars[$urandom_range(0, 52)]);
                repeat (n - 1) source_bytes.push_back(word_chars[$urandom_range(0, 62)]);
            end
            5, 6: begin
                add_digits();
                case ($urandom_range(0, 2))
                    0: begin add_text("."); add_digits(); end
                    1: add_text(".");
                    default: ;
                endcase
            end
            7: begin
                add_text("\"");
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) source_bytes.push_back(8'h0A);
                    else source_bytes.push_back(8'($urandom_range(35, 255)));
                end
                add_text("\"");
            end
            8: begin
                add_text("#");
                n = $urandom_range(0, 5);
                repeat (n) source_bytes.push_back(8'($urandom_range(1, 255)));
                source_bytes.push_back(8'h0A);
            end
            9: begin
                source_bytes.push_back(op_starts[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1)) add_text("=");
            end
            10: add_text(ops[$urandom_range(0, 9)]);
            11: begin
                case ($urandom_range(0, 3))
                    0: source_bytes.push_back(8'h0A);
                    1: source_bytes.push_back(8'h09);
                    2: source_bytes.push_back(8'h0D);
                    default: add_text(" ");
                endcase
            end
            12: source_bytes.push_back(8'($urandom_range(0, 255)));
            13: begin
                add_text("\"");
                add_digits();
                source_bytes.push_back(8'd0);
            end
            default: source_bytes.push_back(8'd0);
        endcase
        if ($urandom_range(0, 2) == 0) add_text(" ");
    endtask

    // Lets the block drain completely, then changes the keyword set.
    task automatic drain_and_configure(logic set);
        while (source_bytes.size() != 0 || push || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= set;
        @(posedge i_clk);
        kw_set = set;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic sets[6];
        int   base;
        sets = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operator, number with and without fraction, strings
        // across lines, comments, unexpected bytes and an unterminated string.
        add_text("(){}[],.-+;/*!!=\n=<=>>===<\t@");
        source_bytes.push_back(8'h80);
        add_text(" 1.5 2.a \"s\nt\" # note\nelse ab0123456789x 3.");
        source_bytes.push_back(8'd0);
        add_text("\"open");
        source_bytes.push_back(8'd0);
        drain_and_configure(1'b1);
        add_text("b2b blockchain blockchains while");
        source_bytes.push_back(8'd0);

        foreach (sets[p]) begin
            drain_and_configure(sets[p]);
            base = source_bytes.size();
            while (source_bytes.size() - base < 30) add_fragment();
            source_bytes.push_back(8'd0);
        end
        drain_and_configure(1'b0);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
